// ===== rtl/wdt_pkg.sv =====
// Package: types, constants and codes shared by the wait deadline tracker.
package wdt_pkg;

    localparam int SLOTS     = 16;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_WAKES = 16;
    localparam int WAKE_W    = $clog2(MAX_WAKES + 1);

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 104;

    localparam logic [2:0] REASON_NONE  = 3'd0;
    localparam logic [2:0] REASON_TIMER = 3'd1;
    localparam logic [2:0] REASON_BAD   = 3'd7;

    typedef enum logic [1:0] {
        REQ_BEGIN  = 2'd0,
        REQ_SIGNAL = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic {
        REG_OK_CODE      = 1'b0,
        REG_TIMEOUT_CODE = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic        pending;
        logic        armed;
        logic [2:0]  reason;
        logic [31:0] deadline;
        logic [63:0] addr;
    } t_slot_rec;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_slot_rec        rec;
    } t_slot_wr;

    typedef struct packed {
        logic        accepted;
        logic        woke;
        logic [3:0]  slot;
        logic [2:0]  reason;
        logic [31:0] result;
        logic [63:0] addr;
        logic        last;
    } t_result;

endpackage

// ===== rtl/wdt_alu.sv =====
// Shared 32-bit adder/subtractor used for deadline arming and expiry compares.
module wdt_alu
    import wdt_pkg::*;
(
    input  t_alu_op     i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    always_comb begin
        case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule

// ===== rtl/wdt_store.sv =====
// Per-slot wait record storage with one read and one write port.
module wdt_store
    import wdt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_slot_rec        o_rd_rec,
    input  t_slot_wr         i_wr
);

    logic        r_pending  [SLOTS];
    logic        r_armed    [SLOTS];
    logic [2:0]  r_reason   [SLOTS];
    logic [31:0] r_deadline [SLOTS];
    logic [63:0] r_addr     [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_pending[i] <= 1'b0;
                r_armed[i]   <= 1'b0;
            end
        end else if (i_wr.en) begin
            r_pending[i_wr.idx] <= i_wr.rec.pending;
            r_armed[i_wr.idx]   <= i_wr.rec.armed;
        end
    end

    // reason/deadline/address are only looked at while pending
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_reason[i_wr.idx]   <= i_wr.rec.reason;
            r_deadline[i_wr.idx] <= i_wr.rec.deadline;
            r_addr[i_wr.idx]     <= i_wr.rec.addr;
        end
    end

    always_comb begin
        o_rd_rec.pending  = r_pending[i_rd_idx];
        o_rd_rec.armed    = r_armed[i_rd_idx];
        o_rd_rec.reason   = r_reason[i_rd_idx];
        o_rd_rec.deadline = r_deadline[i_rd_idx];
        o_rd_rec.addr     = r_addr[i_rd_idx];
    end

endmodule

// ===== rtl/wdt_ctrl.sv =====
// Request sequencer: decode, slot scan, result holding and output register.
module wdt_ctrl
    import wdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output t_result               o_result,
    output logic [IDX_W-1:0]      o_rd_idx,
    input  t_slot_rec             i_rd_rec,
    output t_slot_wr              o_wr,
    output t_alu_op               o_alu_op,
    output logic [31:0]           o_alu_a,
    output logic [31:0]           o_alu_b,
    input  logic [31:0]           i_alu_y
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [WAKE_W-1:0] r_wakes, n_wakes;
    t_result           r_hold, n_hold;
    logic              r_hold_v, n_hold_v;
    logic              r_out_valid;
    t_result           r_out;
    logic [31:0]       r_ok_code, r_tmo_code;

    t_req              r_req;
    logic [3:0]        r_slot;
    logic [2:0]        r_reason;
    logic [31:0]       r_timeout;
    logic [31:0]       r_now;
    logic [31:0]       r_sig;
    logic [63:0]       r_addr;

    logic              in_xfer;
    logic              out_free;
    logic              out_load;
    t_result           out_data;
    logic              slot_ok;
    logic              expired;
    logic              ok;
    logic [31:0]       wake_code;

    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_result        = r_out;
    assign slot_ok         = int'(r_slot) < SLOTS;
    assign wake_code       = (i_rd_rec.reason == REASON_TIMER) ? r_ok_code : r_tmo_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_code  <= '0;
            r_tmo_code <= '1;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_OK_CODE:      r_ok_code  <= i_cfg_data;
                REG_TIMEOUT_CODE: r_tmo_code <= i_cfg_data;
                default:          r_ok_code  <= r_ok_code;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req     <= t_req'(i_s_axis_tuser);
            r_slot    <= i_s_axis_tdata[3:0];
            r_reason  <= i_s_axis_tdata[6:4];
            r_timeout <= i_s_axis_tdata[38:7];
            r_now     <= i_s_axis_tdata[70:39];
            r_sig     <= i_s_axis_tdata[102:71];
            r_addr    <= i_s_axis_tdata[166:103];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_wakes     <= '0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_wakes  <= n_wakes;
            r_hold_v <= n_hold_v;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_wakes  = r_wakes;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        out_load = 1'b0;
        out_data = '0;
        o_wr     = '0;
        ok       = 1'b0;
        expired  = 1'b0;
        o_rd_idx = (r_state == S_SCAN) ? r_idx : IDX_W'(r_slot);
        o_alu_op = (r_state == S_SCAN) ? ALU_SUB : ALU_ADD;
        o_alu_a  = r_now;
        o_alu_b  = (r_state == S_SCAN) ? i_rd_rec.deadline : r_timeout;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state  = (t_req'(i_s_axis_tuser) == REQ_TICK) ? S_SCAN : S_EXEC;
                    n_idx    = '0;
                    n_wakes  = '0;
                    n_hold_v = 1'b0;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data.last = 1'b1;
                    n_state       = S_IDLE;
                    o_wr.idx      = IDX_W'(r_slot);
                    case (r_req)
                        REQ_BEGIN: begin
                            ok = slot_ok && r_reason != REASON_NONE &&
                                 r_reason != REASON_BAD && !i_rd_rec.pending;
                            o_wr.en           = ok;
                            o_wr.rec.pending  = 1'b1;
                            o_wr.rec.armed    = (r_timeout != '0);
                            o_wr.rec.reason   = r_reason;
                            o_wr.rec.deadline = (r_timeout != '0) ? i_alu_y : '0;
                            o_wr.rec.addr     = r_addr;
                            out_data.accepted = ok;
                        end
                        REQ_SIGNAL: begin
                            ok = slot_ok && i_rd_rec.pending && i_rd_rec.reason == r_reason;
                            o_wr.en           = ok;
                            o_wr.rec.reason   = i_rd_rec.reason;
                            o_wr.rec.addr     = i_rd_rec.addr;
                            out_data.accepted = ok;
                            out_data.woke     = ok;
                            if (ok) begin
                                out_data.slot   = r_slot;
                                out_data.reason = r_reason;
                                out_data.result = r_sig;
                                out_data.addr   = i_rd_rec.addr;
                            end
                        end
                        REQ_CLEAR: begin
                            o_wr.en = slot_ok;
                        end
                        default: begin
                            o_wr.en = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                expired = i_rd_rec.pending && i_rd_rec.armed && !i_alu_y[31] &&
                          (r_wakes < WAKE_W'(MAX_WAKES));
                // two wakes queued with the output still full: hold the scan
                if (!(expired && r_hold_v && !out_free)) begin
                    if (expired) begin
                        o_wr.en         = 1'b1;
                        o_wr.idx        = r_idx;
                        o_wr.rec.reason = i_rd_rec.reason;
                        o_wr.rec.addr   = i_rd_rec.addr;
                        n_hold.accepted = 1'b1;
                        n_hold.woke     = 1'b1;
                        n_hold.slot     = 4'(r_idx);
                        n_hold.reason   = i_rd_rec.reason;
                        n_hold.result   = wake_code;
                        n_hold.addr     = i_rd_rec.addr;
                        n_hold.last     = 1'b0;
                        n_hold_v        = 1'b1;
                        n_wakes         = r_wakes + WAKE_W'(1);
                        if (r_hold_v) begin
                            out_load = 1'b1;
                            out_data = r_hold;
                        end
                    end
                    if (r_idx == IDX_W'(SLOTS - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_hold_v) begin
                        out_data = r_hold;
                    end
                    out_data.last = 1'b1;
                    n_hold_v      = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/wait_deadline_tracker.sv =====
// Top level: per-slot wait tracker with deadline expiry scan.
//
//  channel   direction  handshake                     payload
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//  request   in         i_s_axis_tvalid / tready      i_s_axis_tdata, i_s_axis_tuser
//  result    out        o_m_axis_tvalid / tready      o_m_axis_tdata, tuser, tlast
//
//  Begin, signal and clear are accepted, then read and update the slot and load
//  the result once the result register is free. A tick scans one slot per cycle
//  through the shared 32-bit adder unless stalled, then loads the last result.
//  A scan stalls if a new wake meets a held wake and a full result register.
//  Reset (i_rst_n low, synchronous) clears all pending and deadline flags.
module wait_deadline_tracker
    import wdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // slot[3:0], reason[6:4], timeout[38:7], now_tick[70:39],
    // signal_result[102:71], user_addr[166:103], zero[167]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // woke_slot[3:0], woke_reason[6:4], woke_result[38:7], woke_addr[102:39],
    // zero[103]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // accepted[0], woke[1]
    output logic [1:0]            o_m_axis_tuser,
    output logic                  o_m_axis_tlast
);

    t_result          result;
    logic [IDX_W-1:0] rd_idx;
    t_slot_rec        rd_rec;
    t_slot_wr         wr;
    t_alu_op          alu_op;
    logic [31:0]      alu_a;
    logic [31:0]      alu_b;
    logic [31:0]      alu_y;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {1'b0, result.addr, result.result, result.reason, result.slot};
    assign o_m_axis_tuser = {result.woke, result.accepted};
    assign o_m_axis_tlast = result.last;

    wdt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_result        (result),
        .o_rd_idx        (rd_idx),
        .i_rd_rec        (rd_rec),
        .o_wr            (wr),
        .o_alu_op        (alu_op),
        .o_alu_a         (alu_a),
        .o_alu_b         (alu_b),
        .i_alu_y         (alu_y)
    );

    wdt_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .o_rd_rec (rd_rec),
        .i_wr     (wr)
    );

    wdt_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

endmodule

// ===== rtl/wdt_checker.sv =====
// Port-level checker for the wait deadline tracker, bound to the top level.
module wdt_checker
    import wdt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]            o_m_axis_tuser,
    input logic                  o_m_axis_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while previous one in progress");

    a_no_wake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |-> o_m_axis_tdata == '0)
        else $error("non-wake result carries wake fields");

    a_wake_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tuser[0])
        else $error("wake without accept");

    a_midrun_is_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tuser[1])
        else $error("non-final result is not a wake");

endmodule

bind wait_deadline_tracker wdt_checker u_wdt_checker (.*);
